// File: src/mndt_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the midi note duration tracker
// no dependencies
package mndt_pkg;

    localparam int SLOTS_DEF = 32;

    localparam logic [7:0] NOTE_ON_BASE  = 8'h90;
    localparam logic [7:0] NOTE_OFF_BASE = 8'h80;

    typedef enum logic [1:0] {
        OP_NOTE_ON = 2'd0,
        OP_TICK    = 2'd1,
        OP_FLUSH   = 2'd2,
        OP_STOP    = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  channel;
        logic [6:0]  note;
        logic [6:0]  velocity;
        logic [27:0] duration;
    } t_in;

    typedef struct packed {
        logic [7:0] status_byte;
        logic [6:0] data_one;
        logic [6:0] data_two;
        logic       last;
    } t_out;

    // decoded request held in the queue
    typedef struct packed {
        t_op         op;
        logic [3:0]  channel;
        logic [6:0]  note;
        logic [6:0]  velocity;
        logic [27:0] duration;
    } t_cmd;

endpackage

// File: src/mndt_front.sv
`timescale 1ns / 1ps
// request intake: decodes requests into a two-entry queue
// depends on mndt_pkg
module mndt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  mndt_pkg::t_in     i_item,
    input  logic              i_pop,
    output logic              o_q_valid,
    output mndt_pkg::t_cmd    o_q_cmd
);

    mndt_pkg::t_cmd r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           push;
    mndt_pkg::t_cmd cmd;

    assign busy      = (r_cnt == 2'd2);
    assign push      = start && !busy;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cmd   = r_q[r_rp];

    // classify the request
    always_comb begin
        cmd.op       = mndt_pkg::t_op'(i_item.operation);
        cmd.channel  = i_item.channel;
        cmd.note     = i_item.note;
        cmd.velocity = i_item.velocity;
        cmd.duration = i_item.duration;
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

endmodule

// File: src/mndt_back.sv
`timescale 1ns / 1ps
// slot table and sequencer: note on, tick, flush and stop
// depends on mndt_pkg
module mndt_back #(
    parameter int SLOTS = mndt_pkg::SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  mndt_pkg::t_cmd    i_q_cmd,
    output logic              o_pop,
    output logic              o_strobe,
    output mndt_pkg::t_out    o_result
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state r_state, n_state;

    // per-slot busy flag and channel in flops
    logic [SLOTS-1:0] r_valid, n_valid;
    logic [3:0]       r_chan [SLOTS];

    // note and countdown memory
    logic [38:0]      mem [SLOTS];
    logic [38:0]      r_rd;
    logic             we;
    logic [IW-1:0]    waddr;
    logic [38:0]      wdata;

    mndt_pkg::t_cmd   r_cmd;
    logic [CW-1:0]    r_idx;
    logic             r_p1v;
    logic [IW-1:0]    r_p1i;
    logic             r_pend_v, n_pend_v;
    mndt_pkg::t_out   r_pend, n_pend;
    logic             n_strobe;
    mndt_pkg::t_out   n_result;

    logic [IW-1:0]    pick;
    logic             free_found;
    logic [31:0]      rem_dec;
    logic             hit;
    logic             scan_done;

    // lowest free slot
    always_comb begin
        pick       = '0;
        free_found = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                pick       = IW'(i);
                free_found = 1'b1;
            end
        end
    end

    assign rem_dec   = r_rd[31:0] - 32'd1;
    assign scan_done = (r_idx == CW'(SLOTS));

    // slot evaluation during a scan
    always_comb begin
        hit = 1'b0;
        if (r_p1v && r_valid[r_p1i]) begin
            unique case (r_cmd.op)
                mndt_pkg::OP_TICK:  hit = (rem_dec == 32'd0);
                mndt_pkg::OP_FLUSH: hit = (r_chan[r_p1i] == r_cmd.channel);
                mndt_pkg::OP_STOP:  hit = 1'b1;
                default:            hit = 1'b0;
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_valid  = r_valid;
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        n_strobe = 1'b0;
        n_result = r_pend;
        o_pop    = 1'b0;
        we       = 1'b0;
        waddr    = r_p1i;
        wdata    = {r_rd[38:32], rem_dec};
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_pop = 1'b1;
                    if (i_q_cmd.op == mndt_pkg::OP_NOTE_ON) begin
                        // table full falls back to slot 0
                        waddr          = free_found ? pick : '0;
                        we             = 1'b1;
                        wdata          = {i_q_cmd.note, 4'd0, i_q_cmd.duration};
                        n_valid[waddr] = 1'b1;
                        n_strobe       = 1'b1;
                        n_result.status_byte = mndt_pkg::NOTE_ON_BASE |
                                               {4'd0, i_q_cmd.channel};
                        n_result.data_one    = i_q_cmd.note;
                        n_result.data_two    = i_q_cmd.velocity;
                        n_result.last        = 1'b1;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_p1v && r_valid[r_p1i] && r_cmd.op == mndt_pkg::OP_TICK) begin
                    we = 1'b1;
                end
                if (hit) begin
                    n_valid[r_p1i] = 1'b0;
                    // hold the newest note off back so the final one gets last
                    if (r_pend_v) begin
                        n_strobe      = 1'b1;
                        n_result.last = 1'b0;
                    end
                    n_pend_v = 1'b1;
                    n_pend.status_byte = mndt_pkg::NOTE_OFF_BASE | {4'd0, r_chan[r_p1i]};
                    n_pend.data_one    = r_rd[38:32];
                    n_pend.data_two    = 7'd0;
                    n_pend.last        = 1'b0;
                end
                if (scan_done && !r_p1v) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (r_pend_v) begin
                    n_strobe      = 1'b1;
                    n_result.last = 1'b1;
                end
                n_pend_v = 1'b0;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory port
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd <= mem[r_idx[IW-1:0]];
    end

    // channel store
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_q_valid && i_q_cmd.op == mndt_pkg::OP_NOTE_ON) begin
            r_chan[free_found ? pick : '0] <= i_q_cmd.channel;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pend   <= n_pend;
        o_result <= n_result;
        if (o_pop) begin
            r_cmd <= i_q_cmd;
        end
        r_p1i <= r_idx[IW-1:0];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_pend_v <= 1'b0;
            o_strobe <= 1'b0;
            r_idx    <= '0;
            r_p1v    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_pend_v <= n_pend_v;
            o_strobe <= n_strobe;
            if (r_state == S_SCAN && !scan_done) begin
                r_idx <= r_idx + CW'(1);
                r_p1v <= 1'b1;
            end else begin
                if (r_state != S_SCAN) begin
                    r_idx <= '0;
                end
                r_p1v <= 1'b0;
            end
        end
    end

endmodule

// File: src/midi_note_duration_tracker.sv
`timescale 1ns / 1ps
// top level of the midi note duration tracker
// depends on mndt_pkg, mndt_front, mndt_back
//
// Usage:
//   A request is taken on a rising edge with start high and busy low; its
//   fields travel in i_item. Requests enter a two-entry queue, so busy rises
//   only when two requests are waiting behind the one at work.
//   Results appear on o_result for one cycle each, marked by o_strobe; the
//   receiver cannot stall them. The final result of a request has last set.
//   A note on is written into the queue, popped by the sequencer and
//   answered in its idle state, through the registered o_strobe and o_result.
//   Tick, flush and stop walk every slot, one slot a cycle, through the
//   countdown memory read port: the sequencer pops the request, primes the
//   read port, evaluates each slot, closes the scan and sends the held note
//   off. Note offs come in ascending slot order; each is held until the next
//   one is found, and the final one is sent after the scan, from the closing
//   state.
//   Reset frees every slot at once; there is no clearing pass, the note and
//   countdown memory is only evaluated for busy slots.
module midi_note_duration_tracker #(
    parameter int SLOTS = mndt_pkg::SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  mndt_pkg::t_in     i_item,
    output logic              o_strobe,
    output mndt_pkg::t_out    o_result
);

    logic           q_valid;
    logic           pop;
    mndt_pkg::t_cmd q_cmd;

    mndt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_item    (i_item),
        .i_pop     (pop),
        .o_q_valid (q_valid),
        .o_q_cmd   (q_cmd)
    );

    mndt_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_pop     (pop),
        .o_strobe  (o_strobe),
        .o_result  (o_result)
    );

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the midi note duration tracker
// depends on mndt_pkg and midi_note_duration_tracker

module tb;

    localparam int NSLOT = mndt_pkg::SLOTS_DEF;
    localparam logic [7:0] FREE_MARK = 8'hFF;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            start = 1'b0;
    logic            busy;
    mndt_pkg::t_in   i_item = '0;
    logic            o_strobe;
    mndt_pkg::t_out  o_result;

    // predictor state
    logic [7:0]  tbl_channel [NSLOT];
    logic [6:0]  tbl_note [NSLOT];
    logic [31:0] tbl_remaining [NSLOT];

    mndt_pkg::t_in  pending_requests [$];
    mndt_pkg::t_out expected_msgs [$];
    int   mismatch_count = 0;
    int   send_idle_pct = 27;
    bit   hold_off = 1'b0;

    midi_note_duration_tracker i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always #1 i_clk = ~i_clk;

    // append one note off for a slot and free it
    function automatic void release_slot(int s);
        mndt_pkg::t_out m;
        m.status_byte = mndt_pkg::NOTE_OFF_BASE | {4'h0, tbl_channel[s][3:0]};
        m.data_one    = tbl_note[s];
        m.data_two    = 7'd0;
        m.last        = 1'b0;
        tbl_channel[s] = FREE_MARK;
        expected_msgs.push_back(m);
    endfunction

    // work out the messages an accepted request causes
    function automatic void predict_request(mndt_pkg::t_in r);
        int             pick;
        int             n0;
        mndt_pkg::t_out m;
        pick = 0;
        n0 = expected_msgs.size();
        unique case (mndt_pkg::t_op'(r.operation))
            mndt_pkg::OP_NOTE_ON: begin
                for (int s = NSLOT - 1; s >= 0; s--)
                    if (tbl_channel[s] == FREE_MARK) pick = s;
                tbl_channel[pick]   = {4'h0, r.channel};
                tbl_note[pick]      = r.note;
                tbl_remaining[pick] = {4'h0, r.duration};
                m.status_byte = mndt_pkg::NOTE_ON_BASE | {4'h0, r.channel};
                m.data_one    = r.note;
                m.data_two    = r.velocity;
                m.last        = 1'b0;
                expected_msgs.push_back(m);
            end
            mndt_pkg::OP_TICK: begin
                for (int s = 0; s < NSLOT; s++) begin
                    if (tbl_channel[s] != FREE_MARK) begin
                        tbl_remaining[s] = tbl_remaining[s] - 32'd1;
                        if (tbl_remaining[s] == 32'd0) release_slot(s);
                    end
                end
            end
            mndt_pkg::OP_FLUSH: begin
                for (int s = 0; s < NSLOT; s++)
                    if (tbl_channel[s] == {4'h0, r.channel}) release_slot(s);
            end
            default: begin
                for (int s = 0; s < NSLOT; s++)
                    if (tbl_channel[s] != FREE_MARK) release_slot(s);
            end
        endcase
        if (expected_msgs.size() > n0)
            expected_msgs[expected_msgs.size() - 1].last = 1'b1;
    endfunction

    function automatic mndt_pkg::t_in make_req(mndt_pkg::t_op op, int ch, int nt,
                                               int vel, int dur);
        mndt_pkg::t_in r;
        r.operation = op;
        r.channel   = ch[3:0];
        r.note      = nt[6:0];
        r.velocity  = vel[6:0];
        r.duration  = dur[27:0];
        return r;
    endfunction

    // random request with short durations mostly so notes expire
    function automatic mndt_pkg::t_in rand_req();
        mndt_pkg::t_in r;
        int            sel;
        sel = $urandom_range(99);
        r.channel  = 4'($urandom_range(15));
        r.note     = 7'($urandom_range(127));
        r.velocity = 7'($urandom_range(127));
        if ($urandom_range(9) == 0) r.duration = 28'($urandom);
        else r.duration = 28'($urandom_range(6));
        if (sel < 45) r.operation = mndt_pkg::OP_NOTE_ON;
        else if (sel < 88) r.operation = mndt_pkg::OP_TICK;
        else if (sel < 97) r.operation = mndt_pkg::OP_FLUSH;
        else r.operation = mndt_pkg::OP_STOP;
        return r;
    endfunction

    // driver: present the head of the queue, pop on acceptance
    always @(posedge i_clk) begin
        if (start && !busy) begin
            predict_request(i_item);
            void'(pending_requests.pop_front());
        end
        if (!i_rst_n || hold_off) begin
            start <= 1'b0;
        end else if (start && busy) begin
            start <= 1'b1;
        end else if (pending_requests.size() > 0 &&
                     $urandom_range(99) >= send_idle_pct) begin
            start  <= 1'b1;
            i_item <= pending_requests[0];
        end else begin
            start <= 1'b0;
        end
    end

    // monitor: compare each strobed message with the oldest expectation
    always @(posedge i_clk) begin
        mndt_pkg::t_out e;
        if (i_rst_n && o_strobe) begin
            if (expected_msgs.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected message %h", o_result);
            end else begin
                e = expected_msgs.pop_front();
                if (o_result !== e) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %h %h %h %b got %h %h %h %b",
                                 e.status_byte, e.data_one, e.data_two, e.last,
                                 o_result.status_byte, o_result.data_one,
                                 o_result.data_two, o_result.last);
                end
            end
        end
    end

    task automatic drain_queue();
        wait (pending_requests.size() == 0 && !start);
        @(posedge i_clk);
        wait (expected_msgs.size() == 0);
    endtask

    initial begin
        for (int s = 0; s < NSLOT; s++) begin
            tbl_channel[s] = FREE_MARK;
            tbl_note[s] = '0;
            tbl_remaining[s] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, zero duration, empty ends, table overflow
        pending_requests.push_back(make_req(mndt_pkg::OP_TICK, 0, 0, 0, 0));
        pending_requests.push_back(make_req(mndt_pkg::OP_STOP, 0, 0, 0, 0));
        pending_requests.push_back(make_req(mndt_pkg::OP_FLUSH, 15, 0, 0, 0));
        pending_requests.push_back(make_req(mndt_pkg::OP_NOTE_ON, 15, 127, 127,
                                            28'hFFFFFFF));
        pending_requests.push_back(make_req(mndt_pkg::OP_NOTE_ON, 0, 0, 0, 0));
        pending_requests.push_back(make_req(mndt_pkg::OP_NOTE_ON, 5, 60, 64, 1));
        pending_requests.push_back(make_req(mndt_pkg::OP_NOTE_ON, 5, 61, 1, 2));
        pending_requests.push_back(make_req(mndt_pkg::OP_TICK, 0, 0, 0, 0));
        pending_requests.push_back(make_req(mndt_pkg::OP_TICK, 0, 0, 0, 0));
        pending_requests.push_back(make_req(mndt_pkg::OP_FLUSH, 15, 0, 0, 0));
        for (int i = 0; i < 34; i++)
            pending_requests.push_back(make_req(mndt_pkg::OP_NOTE_ON, i % 16, i,
                                                127 - i, 3));
        pending_requests.push_back(make_req(mndt_pkg::OP_FLUSH, 1, 0, 0, 0));
        pending_requests.push_back(make_req(mndt_pkg::OP_STOP, 0, 0, 0, 0));

        // pause until every expected message has come
        drain_queue();
        hold_off = 1'b1;
        repeat (40) @(posedge i_clk);
        hold_off = 1'b0;

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 76 : 0;
            for (int i = 0; i < 125; i++) pending_requests.push_back(rand_req());
            drain_queue();
        end

        repeat (60) @(posedge i_clk);
        if (mismatch_count == 0 && expected_msgs.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
